// ===== hdl/adrc_pkg.sv =====
// shared types, constants and the exponent table of the compressor core
`default_nettype none

package adrc_pkg;

    // sample format
    localparam int SampleBits = 24;
    localparam int SqBits     = 2 * SampleBits - 1;
    localparam int FsExp      = 2 * (SampleBits - 1);

    // level detector constants
    localparam logic [63:0] FloorQ62 = 64'd4611686018427;
    localparam logic [SqBits-1:0] FloorLim = SqBits'(FloorQ62 >> (62 - FsExp));
    localparam logic signed [15:0] FloorDb = -16'sd15360;
    localparam logic [31:0] LogDbK  = 32'd197283;
    localparam logic [31:0] DbLog2K = 32'd10885;

    // configuration reset values
    localparam logic [14:0] ThresholdRst = 15'd0;
    localparam logic [16:0] InvRatioRst  = 17'd65536;
    localparam logic [15:0] AttackRst    = 16'd64857;
    localparam logic [15:0] ReleaseRst   = 16'd65531;
    localparam logic [12:0] MakeupRst    = 13'd0;
    localparam logic [16:0] UnityQ16     = 17'd65536;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_INV_RATIO = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3,
        CFG_MAKEUP    = 3'd4,
        CFG_BYPASS    = 3'd5
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_NORM,
        S_LOG,
        S_DB,
        S_GC,
        S_SM1,
        S_SM2,
        S_EXP,
        S_POW,
        S_APL,
        S_APR,
        S_OUT
    } t_state;

    typedef logic [15:0][31:0] t_rom;

    // round-down integer square root
    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        x = v;
        for (int i = 0; i < 32; i++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(2^-(k+1)) in Q2.30, each entry the square root of the one before
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] c;
        c = f_isqrt(64'd2 << 60);
        for (int k = 0; k < 16; k++) begin
            rom[k] = c[31:0];
            c = f_isqrt(c << 30);
        end
        return rom;
    endfunction

    localparam t_rom PowRom = f_build_rom();

endpackage

`default_nettype wire

// ===== hdl/audio_dynamic_range_compressor_core.sv =====
// stereo feedforward compressor core built around one shared multiplier
//
//  channel | direction | handshake                 | contents
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready   | left and right sample
//  out     | output    | o_out_valid / i_out_ready | scaled samples, reductions
//  cfg     | input     | i_cfg_valid / o_cfg_ready | register index, write data
//
// a frame runs from one input transaction through the normalize shifts (0 to 20), 16 log
// squarings, 16 exponent table steps and single steps between them.
// floor-level frames skip normalize and log; bypass frames go straight to the output state.
// o_in_ready is high only while the sequencer is idle.
// a finished frame waits in the output register, the next frame is taken meanwhile.
// reset is synchronous active low; it restores register defaults and clears state.
`default_nettype none

module audio_dynamic_range_compressor_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [23:0] i_left_sample,
    input  wire logic signed [23:0] i_right_sample,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [23:0]      o_left_out,
    output logic signed [23:0]      o_right_out,
    output logic signed [23:0]      o_left_reduction,
    output logic signed [23:0]      o_right_reduction,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [16:0]        i_cfg_data
);

    // configuration registers
    logic [14:0] r_threshold;
    logic [16:0] r_inv;
    logic [15:0] r_attack;
    logic [15:0] r_release;
    logic [12:0] r_makeup;
    logic        r_bypass;

    // datapath registers
    adrc_pkg::t_state r_state, n_state;
    logic signed [23:0] r_xl, n_xl, r_xr, n_xr;
    logic [46:0]        r_w, n_w;
    logic [4:0]         r_shift, n_shift;
    logic [31:0]        r_m, n_m;
    logic [15:0]        r_frac, n_frac;
    logic [3:0]         r_k, n_k;
    logic signed [15:0] r_xg, n_xg;
    logic [15:0]        r_xlv, n_xlv;
    logic [15:0]        r_c, n_c;
    logic [40:0]        r_acc, n_acc;
    logic [23:0]        r_y, n_y;
    logic signed [23:0] r_e, n_e;
    logic signed [23:0] r_yl, n_yl, r_yr, n_yr, r_rl, n_rl, r_rr, n_rr;
    logic               r_out_valid, n_out_valid;
    logic signed [23:0] r_ol, n_ol, r_or, n_or, r_oll, n_oll, r_orr, n_orr;

    // shared multiplier
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_mul_p;

    // helper nets
    logic signed [24:0] w_sum;
    logic signed [23:0] w_mix;
    logic [23:0]        w_mag;
    logic [20:0]        w_neg;
    logic [39:0]        w_dbr;
    logic signed [15:0] w_t;
    logic [15:0]        w_diff;
    logic [16:0]        w_inv_c, w_om;
    logic [23:0]        w_x16;
    logic [15:0]        w_csel;
    logic [16:0]        w_omc;
    logic [40:0]        w_smsum;
    logic signed [25:0] w_g;
    logic [24:0]        w_gmag;
    logic [22:0]        w_emag;
    logic [31:0]        w_m_sq;
    logic signed [23:0] w_cur_x;
    logic [23:0]        w_cur_mag;
    logic signed [7:0]  w_n;
    logic signed [8:0]  w_s;
    logic [63:0]        w_round, w_sh;
    logic signed [23:0] w_ysat, w_red;
    logic               w_in_acc, w_out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == adrc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out        = r_ol;
    assign o_right_out       = r_or;
    assign o_left_reduction  = r_oll;
    assign o_right_reduction = r_orr;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= adrc_pkg::ThresholdRst;
            r_inv       <= adrc_pkg::InvRatioRst;
            r_attack    <= adrc_pkg::AttackRst;
            r_release   <= adrc_pkg::ReleaseRst;
            r_makeup    <= adrc_pkg::MakeupRst;
            r_bypass    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                adrc_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[14:0];
                adrc_pkg::CFG_INV_RATIO: r_inv       <= i_cfg_data;
                adrc_pkg::CFG_ATTACK:    r_attack    <= i_cfg_data[15:0];
                adrc_pkg::CFG_RELEASE:   r_release   <= i_cfg_data[15:0];
                adrc_pkg::CFG_MAKEUP:    r_makeup    <= i_cfg_data[12:0];
                adrc_pkg::CFG_BYPASS:    r_bypass    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // operand helpers
    always_comb begin
        w_sum  = {r_xl[23], r_xl} + {r_xr[23], r_xr};
        w_mix  = w_sum[24:1];
        w_mag  = w_mix[23] ? 24'(-w_mix) : w_mix;
        w_neg  = {r_shift, 16'd0} - {5'd0, r_frac};
        w_t    = {r_threshold[14], r_threshold};
        w_diff = 16'(r_xg - w_t);
        w_inv_c = (r_inv > adrc_pkg::UnityQ16) ? adrc_pkg::UnityQ16 : r_inv;
        w_om   = adrc_pkg::UnityQ16 - w_inv_c;
        w_x16  = {r_xlv, 8'd0};
        w_csel = (w_x16 > r_y) ? r_attack : r_release;
        w_omc  = adrc_pkg::UnityQ16 - {1'b0, r_c};
        w_g    = {{5{r_makeup[12]}}, r_makeup, 8'd0} - {2'd0, r_y};
        w_gmag = w_g[25] ? 25'(-w_g) : w_g[24:0];
        w_cur_x   = (r_state == adrc_pkg::S_APL) ? r_xl : r_xr;
        w_cur_mag = w_cur_x[23] ? 24'(-w_cur_x) : w_cur_x;
        w_n = r_e[23:16];
        w_s = 9'sd30 - {w_n[7], w_n};
    end

    // multiplier operand select
    always_comb begin
        unique case (r_state)
            adrc_pkg::S_SQ: begin
                w_mul_a = {8'd0, w_mag};
                w_mul_b = {8'd0, w_mag};
            end
            adrc_pkg::S_LOG: begin
                w_mul_a = r_m;
                w_mul_b = r_m;
            end
            adrc_pkg::S_DB: begin
                w_mul_a = {11'd0, w_neg};
                w_mul_b = adrc_pkg::LogDbK;
            end
            adrc_pkg::S_GC: begin
                w_mul_a = {16'd0, w_diff};
                w_mul_b = {15'd0, w_om};
            end
            adrc_pkg::S_SM1: begin
                w_mul_a = {16'd0, w_csel};
                w_mul_b = {8'd0, r_y};
            end
            adrc_pkg::S_SM2: begin
                w_mul_a = {15'd0, w_omc};
                w_mul_b = {8'd0, w_x16};
            end
            adrc_pkg::S_EXP: begin
                w_mul_a = {7'd0, w_gmag};
                w_mul_b = adrc_pkg::DbLog2K;
            end
            adrc_pkg::S_POW: begin
                w_mul_a = r_m;
                w_mul_b = adrc_pkg::PowRom[r_k];
            end
            adrc_pkg::S_APL, adrc_pkg::S_APR: begin
                w_mul_a = {8'd0, w_cur_mag};
                w_mul_b = r_m;
            end
            default: begin
                w_mul_a = 32'd0;
                w_mul_b = 32'd0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // post-multiply logic
    always_comb begin
        w_dbr   = w_mul_p[39:0] + 40'h80_0000;
        w_smsum = r_acc + w_mul_p[40:0];
        w_emag  = w_mul_p[38:16];
        w_m_sq  = w_mul_p[61:30];
        w_round = w_mul_p + (64'd1 << (w_s[5:0] - 6'd1));
        w_sh    = (w_s > 9'sd62) ? 64'd0 : (w_round >> w_s[5:0]);
        if (w_cur_x[23]) begin
            w_ysat = (w_sh > 64'h80_0000) ? 24'sh80_0000 : 24'(-w_sh[23:0]);
        end else begin
            w_ysat = (w_sh > 64'h7F_FFFF) ? 24'sh7F_FFFF : w_sh[23:0];
        end
        w_red = r_e[23] ? 24'(w_cur_x - w_ysat) : 24'sd0;
    end

    // sequencer: next state and datapath updates
    always_comb begin
        n_state = r_state;
        n_xl = r_xl;   n_xr = r_xr;   n_w = r_w;     n_shift = r_shift;
        n_m = r_m;     n_frac = r_frac; n_k = r_k;   n_xg = r_xg;
        n_xlv = r_xlv; n_c = r_c;     n_acc = r_acc; n_y = r_y;   n_e = r_e;
        n_yl = r_yl;   n_yr = r_yr;   n_rl = r_rl;   n_rr = r_rr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_ol = r_ol;   n_or = r_or;   n_oll = r_oll; n_orr = r_orr;
        unique case (r_state)
            adrc_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_xl = i_left_sample;
                    n_xr = i_right_sample;
                    if (r_bypass) begin
                        n_yl = i_left_sample;
                        n_yr = i_right_sample;
                        n_rl = 24'sd0;
                        n_rr = 24'sd0;
                        n_state = adrc_pkg::S_OUT;
                    end else begin
                        n_state = adrc_pkg::S_SQ;
                    end
                end
            end
            adrc_pkg::S_SQ: begin
                // quiet signals take the floor level
                if (w_mul_p[46:0] <= adrc_pkg::FloorLim) begin
                    n_xg = adrc_pkg::FloorDb;
                    n_state = adrc_pkg::S_GC;
                end else begin
                    n_w = w_mul_p[46:0];
                    n_shift = 5'd0;
                    n_state = adrc_pkg::S_NORM;
                end
            end
            adrc_pkg::S_NORM: begin
                // one bit of normalization per cycle
                if (r_w[46]) begin
                    n_m = {1'b0, r_w[46:16]};
                    n_frac = 16'd0;
                    n_k = 4'd0;
                    n_state = adrc_pkg::S_LOG;
                end else begin
                    n_w = {r_w[45:0], 1'b0};
                    n_shift = r_shift + 5'd1;
                end
            end
            adrc_pkg::S_LOG: begin
                // one log2 fraction bit per squaring
                n_frac = {r_frac[14:0], w_m_sq[31]};
                n_m = w_m_sq[31] ? {1'b0, w_m_sq[31:1]} : w_m_sq;
                n_k = r_k + 4'd1;
                if (r_k == 4'd15) begin
                    n_state = adrc_pkg::S_DB;
                end
            end
            adrc_pkg::S_DB: begin
                n_xg = 16'sd0 - $signed({1'b0, w_dbr[38:24]});
                n_state = adrc_pkg::S_GC;
            end
            adrc_pkg::S_GC: begin
                // hard knee
                n_xlv = (r_xg >= w_t) ? w_mul_p[31:16] : 16'd0;
                n_state = adrc_pkg::S_SM1;
            end
            adrc_pkg::S_SM1: begin
                n_c = w_csel;
                n_acc = {1'b0, w_mul_p[39:0]};
                n_state = adrc_pkg::S_SM2;
            end
            adrc_pkg::S_SM2: begin
                n_y = w_smsum[39:16];
                n_state = adrc_pkg::S_EXP;
            end
            adrc_pkg::S_EXP: begin
                n_e = w_g[25] ? 24'sd0 - $signed({1'b0, w_emag})
                              : $signed({1'b0, w_emag});
                n_m = 32'h4000_0000;
                n_k = 4'd0;
                n_state = adrc_pkg::S_POW;
            end
            adrc_pkg::S_POW: begin
                // one table factor per fraction bit
                if (r_e[4'd15 - r_k]) begin
                    n_m = w_m_sq;
                end
                n_k = r_k + 4'd1;
                if (r_k == 4'd15) begin
                    n_state = adrc_pkg::S_APL;
                end
            end
            adrc_pkg::S_APL: begin
                n_yl = w_ysat;
                n_rl = w_red;
                n_state = adrc_pkg::S_APR;
            end
            adrc_pkg::S_APR: begin
                n_yr = w_ysat;
                n_rr = w_red;
                n_state = adrc_pkg::S_OUT;
            end
            adrc_pkg::S_OUT: begin
                // hand over once the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_ol = r_yl;
                    n_or = r_yr;
                    n_oll = r_rl;
                    n_orr = r_rr;
                    n_state = adrc_pkg::S_IDLE;
                end
            end
            default: n_state = adrc_pkg::S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= adrc_pkg::S_IDLE;
            r_y         <= 24'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_y         <= n_y;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_xl <= n_xl;   r_xr <= n_xr;   r_w <= n_w;     r_shift <= n_shift;
        r_m <= n_m;     r_frac <= n_frac; r_k <= n_k;   r_xg <= n_xg;
        r_xlv <= n_xlv; r_c <= n_c;     r_acc <= n_acc; r_e <= n_e;
        r_yl <= n_yl;   r_yr <= n_yr;   r_rl <= n_rl;   r_rr <= n_rr;
        r_ol <= n_ol;   r_or <= n_or;   r_oll <= n_oll; r_orr <= n_orr;
    end

    // smoother state moves only in its update step
    a_y_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != adrc_pkg::S_SM2) |=> $stable(r_y))
        else $error("smoothed reduction changed outside its update");

    // mantissa stays in [1,2) through the log squarings
    a_log_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == adrc_pkg::S_LOG) |-> (!r_m[31] && r_m[30]))
        else $error("log mantissa out of range");

    // normalization only runs on a nonzero square
    a_norm_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == adrc_pkg::S_NORM) |-> (r_w != 47'd0))
        else $error("normalizing a zero square");

    // a pending result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_ol)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== tb/sv/tb_audio_dynamic_range_compressor_core.sv =====
// self-checking testbench of the stereo compressor core with its own gain predictor
`default_nettype none

module tb_audio_dynamic_range_compressor_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 2000000;
    localparam int DrainWait  = 150;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } t_frame;

    typedef struct {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
        logic signed [23:0] left_red;
        logic signed [23:0] right_red;
    } t_gained;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic signed [23:0] in_left = '0;
    logic signed [23:0] in_right = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [16:0]        cfg_data = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_cfg_ready;
    logic signed [23:0] o_left_out;
    logic signed [23:0] o_right_out;
    logic signed [23:0] o_left_reduction;
    logic signed [23:0] o_right_reduction;

    audio_dynamic_range_compressor_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_left_sample    (in_left),
        .i_right_sample   (in_right),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_left_reduction (o_left_reduction),
        .o_right_reduction(o_right_reduction),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers and the smoothed reduction
    logic [14:0] thr_reg;
    logic [16:0] ratio_reg;
    logic [15:0] atk_reg;
    logic [15:0] rel_reg;
    logic [12:0] makeup_reg;
    logic        bypass_reg;
    logic [23:0] smooth_db;
    logic [31:0] exp_table [16];

    t_frame  pending_frames [$];
    t_gained expected_frames [$];
    int      n_sent = 0;
    int      n_taken = 0;
    int      n_err = 0;
    int      cycles = 0;
    logic    hold = 1'b0;

    // floor square root by bisection
    function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'h1_0000_0000;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // detector level in Q7.8 dB
    function automatic longint detect_db(input logic [63:0] mag);
        logic [63:0] sq;
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] neg;
        int          p;
        sq = mag * mag;
        frac = 0;
        if (sq <= (64'd4611686018427 >> 16)) return -15360;
        p = 63;
        while (!sq[p]) p--;
        mant = (p >= 30) ? (sq >> (p - 30)) : (sq << (30 - p));
        for (int k = 0; k < 16; k++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd2 << 30)) begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        neg = 64'(46 - p) * 65536 - frac;
        return -longint'((neg * 197283 + (64'd1 << 23)) >> 24);
    endfunction

    function automatic logic signed [23:0] scale_sample(input longint x, input logic [63:0] m,
                                                       input int s);
        logic [63:0] mag;
        logic [63:0] p;
        longint      v;
        mag = (x < 0) ? 64'(-x) : 64'(x);
        if (s > 62) p = 0;
        else p = (mag * m + (64'd1 << (s - 1))) >> s;
        v = (x < 0) ? -longint'(p) : longint'(p);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    // work out the gained frame and, outside bypass, advance the smoothed reduction
    function automatic t_gained compress_frame(input t_frame fr);
        t_gained     res;
        longint      mix;
        longint      xg;
        longint      thr;
        longint      g;
        longint      e;
        longint      n;
        logic [63:0] inv;
        logic [63:0] xl;
        logic [63:0] x16;
        logic [63:0] y;
        logic [63:0] c;
        logic [63:0] f;
        logic [63:0] m;
        res.left_out = fr.left;
        res.right_out = fr.right;
        res.left_red = '0;
        res.right_red = '0;
        if (bypass_reg) return res;
        mix = (longint'(fr.left) + longint'(fr.right)) >>> 1;
        xg = detect_db((mix < 0) ? 64'(-mix) : 64'(mix));
        thr = longint'($signed(thr_reg));
        inv = (ratio_reg > adrc_pkg::UnityQ16) ? 64'd65536 : 64'(ratio_reg);
        xl = 0;
        if (xg >= thr) xl = (64'(xg - thr) * (64'd65536 - inv)) >> 16;
        y = 64'(smooth_db);
        x16 = xl << 8;
        c = (x16 > y) ? 64'(atk_reg) : 64'(rel_reg);
        y = ((c * y + (64'd65536 - c) * x16) >> 16) & 64'hFF_FFFF;
        smooth_db = y[23:0];
        g = longint'($signed(makeup_reg)) * 256 - longint'(y);
        if (g >= 0) e = longint'((64'(g) * 10885) >> 16);
        else e = -longint'((64'(-g) * 10885) >> 16);
        f = 64'(e) & 64'hFFFF;
        n = (e - longint'(f)) >>> 16;
        m = 64'd1 << 30;
        for (int k = 0; k < 16; k++) begin
            if (f[15 - k]) m = (m * 64'(exp_table[k])) >> 30;
        end
        res.left_out = scale_sample(fr.left, m, int'(30 - n));
        res.right_out = scale_sample(fr.right, m, int'(30 - n));
        if (e < 0) begin
            res.left_red = fr.left - res.left_out;
            res.right_red = fr.right - res.right_out;
        end
        return res;
    endfunction

    // sender: one frame transaction at a time with random gaps
    int   send_gap = 0;
    logic send_up = 1'b0;
    logic send_burst = 1'b0;
    t_frame next_frame;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_up = 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_frames.push_back(compress_frame('{in_left, in_right}));
                n_taken++;
                if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 8);
                send_up = 1'b0;
            end
            if (!send_up) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_frames.size() > 0) begin
                    next_frame = pending_frames.pop_front();
                    in_left <= next_frame.left;
                    in_right <= next_frame.right;
                    send_up = 1'b1;
                end
            end
            in_valid <= send_up;
        end
    end

    // receiver: compare each result transaction with the oldest expected frame
    int   recv_stall = 0;
    logic recv_burst = 1'b0;
    t_gained want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_frames.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result transaction");
                end else begin
                    want = expected_frames.pop_front();
                    if (o_left_out !== want.left_out || o_right_out !== want.right_out ||
                        o_left_reduction !== want.left_red ||
                        o_right_reduction !== want.right_red) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     want.left_out, want.right_out, want.left_red,
                                     want.right_red, o_left_out, o_right_out,
                                     o_left_reduction, o_right_reduction);
                    end
                end
                if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 8);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            out_ready <= !hold && recv_stall == 0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // long receiver hold-off so the core backs up its input
    initial begin
        wait (n_taken >= 300);
        @(posedge i_clk);
        hold <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold <= 1'b0;
    end

    task automatic write_reg(input adrc_pkg::t_cfg_idx idx, input logic [16:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!(cfg_valid && o_cfg_ready));
        case (idx)
            adrc_pkg::CFG_THRESHOLD: thr_reg = data[14:0];
            adrc_pkg::CFG_INV_RATIO: ratio_reg = data;
            adrc_pkg::CFG_ATTACK:    atk_reg = data[15:0];
            adrc_pkg::CFG_RELEASE:   rel_reg = data[15:0];
            adrc_pkg::CFG_MAKEUP:    makeup_reg = data[12:0];
            adrc_pkg::CFG_BYPASS:    bypass_reg = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(input int thr, input int ratio, input int atk, input int rel,
                           input int mk, input bit byp);
        wait (n_taken == n_sent && expected_frames.size() == 0);
        repeat (DrainWait) @(posedge i_clk);
        write_reg(adrc_pkg::CFG_THRESHOLD, 17'(thr));
        write_reg(adrc_pkg::CFG_INV_RATIO, 17'(ratio));
        write_reg(adrc_pkg::CFG_ATTACK, 17'(atk));
        write_reg(adrc_pkg::CFG_RELEASE, 17'(rel));
        write_reg(adrc_pkg::CFG_MAKEUP, 17'(mk));
        write_reg(adrc_pkg::CFG_BYPASS, 17'(byp));
    endtask

    task automatic queue_frame(input logic signed [23:0] l, input logic signed [23:0] r);
        pending_frames.push_back('{l, r});
        n_sent++;
    endtask

    // random frames, level spread over the whole dB range
    task automatic queue_random(input int count);
        logic signed [23:0] l;
        logic signed [23:0] r;
        for (int i = 0; i < count; i++) begin
            l = $signed(24'($urandom)) >>> $urandom_range(0, 23);
            if ($urandom_range(0, 3) == 0) r = $signed(24'($urandom)) >>> $urandom_range(0, 23);
            else r = l + $signed(24'($urandom_range(0, 255))) - 24'sd128;
            queue_frame(l, r);
        end
    endtask

    initial begin
        logic [63:0] c;
        c = sqrt_floor(64'd2 << 60);
        for (int k = 0; k < 16; k++) begin
            exp_table[k] = c[31:0];
            c = sqrt_floor(c << 30);
        end
        thr_reg = adrc_pkg::ThresholdRst;
        ratio_reg = adrc_pkg::InvRatioRst;
        atk_reg = adrc_pkg::AttackRst;
        rel_reg = adrc_pkg::ReleaseRst;
        makeup_reg = adrc_pkg::MakeupRst;
        bypass_reg = 1'b0;
        smooth_db = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, sample extremes
        queue_frame(24'sh7FFFFF, 24'sh7FFFFF);
        queue_frame(-24'sh800000, -24'sh800000);
        queue_frame(24'sh7FFFFF, -24'sh800000);
        queue_frame(24'sd0, 24'sd0);
        queue_frame(-24'sd1, -24'sd1);
        queue_frame(24'sd8400, 24'sd8400);

        // hard limiter, fast poles, full makeup
        set_all(-15360, 0, 0, 0, 3072, 1'b0);
        queue_frame(24'sh7FFFFF, 24'sh7FFFFF);
        queue_frame(-24'sh800000, -24'sh800000);
        queue_frame(24'sd8390, 24'sd8390);
        queue_frame(24'sd8389, 24'sd8389);
        queue_frame(24'sd1000, -24'sd1000);

        // slow poles, lowest makeup, ratio register above unity, unused indexes
        set_all(-7680, 131071, 65535, 65535, -3072, 1'b0);
        write_reg(adrc_pkg::t_cfg_idx'(3'd6), 17'h1FFFF);
        write_reg(adrc_pkg::t_cfg_idx'(3'd7), 17'h00000);
        queue_frame(24'sh7FFFFF, 24'sh7FFFFF);
        queue_frame(-24'sh400000, 24'sh123456);

        // threshold above 0 dB, largest ratio
        set_all(16383, 655, 100, 60000, 0, 1'b0);
        queue_frame(24'sh7FFFFF, 24'sh7FFFFF);
        queue_frame(24'sh100000, 24'sh0FFFFF);

        // pass-through
        set_all(-15360, 655, 0, 0, 3072, 1'b1);
        queue_frame(24'sh7FFFFF, -24'sh800000);
        queue_frame(24'sh555555, -24'sh2AAAAA);

        // random settings between phases
        for (int ph = 0; ph < 8; ph++) begin
            set_all(-int'($urandom_range(0, 15360)), $urandom_range(655, 65536),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    int'($urandom_range(0, 6144)) - 3072, ph == 5);
            queue_random(180);
        end

        wait (n_taken == n_sent && expected_frames.size() == 0);
        repeat (DrainWait) @(posedge i_clk);
        if (n_err == 0 && expected_frames.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/adrc_pkg.sv
hdl/audio_dynamic_range_compressor_core.sv
tb/sv/tb_audio_dynamic_range_compressor_core.sv
